// File: sv/tlnb_pkg.sv
package tlnb_pkg;

  // Result phase codes
  localparam logic [1:0] PH_CODE_GREEN  = 2'd0;
  localparam logic [1:0] PH_CODE_YELLOW = 2'd1;
  localparam logic [1:0] PH_CODE_RED    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_DARK_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_GREEN_SECONDS  = 2'd1;
  localparam logic [1:0] REG_YELLOW_SECONDS = 2'd2;
  localparam logic [1:0] REG_RED_SECONDS    = 2'd3;

  // Reset values of the configuration registers
  localparam logic [11:0] DARK_THRESHOLD_RST = 12'd2000;
  localparam logic [7:0]  GREEN_SECONDS_RST  = 8'd5;
  localparam logic [7:0]  YELLOW_SECONDS_RST = 8'd2;
  localparam logic [7:0]  RED_SECONDS_RST    = 8'd5;

  localparam logic [8:0] MAX_TICKS = 9'd510;

  typedef enum logic [2:0] {
    PH_GREEN  = 3'b001,
    PH_YELLOW = 3'b010,
    PH_RED    = 3'b100
  } phase_t;

  // Phase length in seconds, zero read as one
  function automatic logic [7:0] tlnb_phase_secs(phase_t ph, logic [7:0] g_s,
                                                 logic [7:0] y_s, logic [7:0] r_s);
    logic [7:0] s;
    unique case (ph)
      PH_YELLOW: s = y_s;
      PH_RED:    s = r_s;
      default:   s = g_s;
    endcase
    return (s == 8'd0) ? 8'd1 : s;
  endfunction

  function automatic phase_t tlnb_next_phase(phase_t ph);
    phase_t n;
    unique case (ph)
      PH_GREEN:  n = PH_YELLOW;
      PH_YELLOW: n = PH_RED;
      default:   n = PH_GREEN;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] tlnb_phase_code(phase_t ph);
    logic [1:0] c;
    unique case (ph)
      PH_YELLOW: c = PH_CODE_YELLOW;
      PH_RED:    c = PH_CODE_RED;
      default:   c = PH_CODE_GREEN;
    endcase
    return c;
  endfunction

endpackage

// File: sv/tlnb_if.sv
interface tlnb_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] light_level;

  modport source (output valid, output light_level, input ready);
  modport sink   (input valid, input light_level, output ready);
endinterface

interface tlnb_out_if;
  logic       valid;
  logic       ready;
  logic       red_on;
  logic       yellow_on;
  logic       green_on;
  logic       night_mode;
  logic [1:0] phase_now;
  logic [7:0] seconds_left;

  modport source (output valid, output red_on, output yellow_on, output green_on,
                  output night_mode, output phase_now, output seconds_left,
                  input ready);
  modport sink   (input valid, input red_on, input yellow_on, input green_on,
                  input night_mode, input phase_now, input seconds_left,
                  output ready);
endinterface

// File: sv/traffic_light_night_blink.sv
// Throughput: one beat per cycle unless the output stalls; the whole tick
// update is one combinational pass from the state registers and the input
// beat into the result register; its beat is valid in the next cycle.
// Reset (rst_n low, synchronous): phase green, load pending, blink and dark
// flags clear, configuration registers back to their defaults.
module traffic_light_night_blink
  import tlnb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tlnb_in_if.sink     in_ch,
  tlnb_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [11:0] cfg_data
);

  // Configuration registers
  logic [11:0] dark_thr_r;
  logic [7:0]  green_s_r, yellow_s_r, red_s_r;

  // Tick state
  phase_t      phase_r, phase_nxt;
  logic [8:0]  ticks_r, ticks_nxt;
  logic        blink_r, blink_nxt;
  logic        was_dark_r, was_dark_nxt;
  logic [7:0]  sec_cnt_r, sec_cnt_nxt;

  // Result register
  logic        out_valid_r;
  logic        red_r, yellow_r, green_r, night_r;
  logic [1:0]  phase_code_r;
  logic [7:0]  shown_r;
  logic        red_nxt, yellow_nxt, green_nxt, night_nxt;
  logic [1:0]  phase_code_nxt;
  logic [7:0]  shown_nxt;

  logic        accept;

  // Take a beat whenever the result slot is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_thr_r <= DARK_THRESHOLD_RST;
      green_s_r  <= GREEN_SECONDS_RST;
      yellow_s_r <= YELLOW_SECONDS_RST;
      red_s_r    <= RED_SECONDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_DARK_THRESHOLD: dark_thr_r <= cfg_data;
        REG_GREEN_SECONDS:  green_s_r  <= cfg_data[7:0];
        REG_YELLOW_SECONDS: yellow_s_r <= cfg_data[7:0];
        REG_RED_SECONDS:    red_s_r    <= cfg_data[7:0];
      endcase
    end
  end

  // Compute the next state and the result of one tick
  always_comb begin
    phase_t     ph_eff, ph_day, ph_after;
    logic [8:0] tr_load, tr_day, tr_dec, day_ticks;
    logic [7:0] secs_day, sc_base;
    logic       blink_in, start, blink_day;

    ph_eff    = (phase_r == PH_YELLOW || phase_r == PH_RED) ? phase_r : PH_GREEN;
    tr_load   = (ticks_r == 9'd0)
              ? {tlnb_phase_secs(ph_eff, green_s_r, yellow_s_r, red_s_r), 1'b0}
              : ticks_r;

    ph_day    = was_dark_r ? PH_GREEN : ph_eff;
    secs_day  = tlnb_phase_secs(ph_day, green_s_r, yellow_s_r, red_s_r);
    day_ticks = {secs_day, 1'b0};
    tr_day    = was_dark_r ? day_ticks : tr_load;
    blink_in  = was_dark_r ? 1'b0 : blink_r;
    start     = (tr_day == day_ticks);
    blink_day = start || !blink_in;
    sc_base   = start ? secs_day - 8'd1 : sec_cnt_r;
    tr_dec    = tr_day - 9'd1;
    ph_after  = tlnb_next_phase(ph_day);

    phase_nxt      = phase_r;
    ticks_nxt      = ticks_r;
    blink_nxt      = blink_r;
    was_dark_nxt   = was_dark_r;
    sec_cnt_nxt    = sec_cnt_r;
    red_nxt        = 1'b0;
    yellow_nxt     = 1'b0;
    green_nxt      = 1'b0;
    night_nxt      = 1'b0;
    phase_code_nxt = PH_CODE_GREEN;
    shown_nxt      = 8'd0;

    if (in_ch.light_level > dark_thr_r) begin
      // Night: hold the cycle, toggle yellow
      phase_nxt    = ph_eff;
      ticks_nxt    = tr_load;
      was_dark_nxt = 1'b1;
      blink_nxt    = !blink_r;
      yellow_nxt   = !blink_r;
      night_nxt    = 1'b1;
    end else begin
      // Day: drive the phase lamp and count down
      was_dark_nxt   = 1'b0;
      blink_nxt      = blink_day;
      red_nxt        = (ph_day == PH_RED) && blink_day;
      yellow_nxt     = (ph_day == PH_YELLOW) && blink_day;
      green_nxt      = (ph_day == PH_GREEN) && blink_day;
      phase_code_nxt = tlnb_phase_code(ph_day);
      shown_nxt      = blink_day ? sc_base : 8'd0;
      sec_cnt_nxt    = blink_day ? sc_base - 8'd1 : sc_base;
      if (tr_dec == 9'd0) begin
        phase_nxt = ph_after;
        ticks_nxt = {tlnb_phase_secs(ph_after, green_s_r, yellow_s_r, red_s_r), 1'b0};
      end else begin
        phase_nxt = ph_day;
        ticks_nxt = tr_dec;
      end
    end
  end

  // Advance tick state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_GREEN;
      ticks_r    <= 9'd0;
      blink_r    <= 1'b0;
      was_dark_r <= 1'b0;
      sec_cnt_r  <= 8'd0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      ticks_r    <= ticks_nxt;
      blink_r    <= blink_nxt;
      was_dark_r <= was_dark_nxt;
      sec_cnt_r  <= sec_cnt_nxt;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      red_r        <= red_nxt;
      yellow_r     <= yellow_nxt;
      green_r      <= green_nxt;
      night_r      <= night_nxt;
      phase_code_r <= phase_code_nxt;
      shown_r      <= shown_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.red_on       = red_r;
  assign out_ch.yellow_on    = yellow_r;
  assign out_ch.green_on     = green_r;
  assign out_ch.night_mode   = night_r;
  assign out_ch.phase_now    = phase_code_r;
  assign out_ch.seconds_left = shown_r;

`ifndef SYNTH
  a_night_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && night_r |-> !red_r && !green_r && phase_code_r == PH_CODE_GREEN
                               && shown_r == 8'd0)
    else $error("night beat drives a day lamp or display");

  a_one_lamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({red_r, yellow_r, green_r}))
    else $error("more than one lamp lit");

  a_lamp_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !night_r && (red_r || yellow_r || green_r) |->
      (red_r && phase_code_r == PH_CODE_RED) || (yellow_r && phase_code_r == PH_CODE_YELLOW)
      || (green_r && phase_code_r == PH_CODE_GREEN))
    else $error("lit lamp does not match phase");

  a_ticks_range: assert property (@(posedge clk) disable iff (!rst_n)
    ticks_r <= MAX_TICKS)
    else $error("tick count out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(phase_r) && $stable(ticks_r) && $stable(sec_cnt_r))
    else $error("tick state moved without an input beat");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tlnb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_TICKS = 1500;

  // One result beat as the lamp head should show it
  typedef struct packed {
    logic       red;
    logic       yellow;
    logic       green;
    logic       night;
    logic [1:0] phase;
    logic [7:0] secs;
  } lamp_beat_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [11:0] cfg_data;

  tlnb_in_if  in_if();
  tlnb_out_if out_if();

  traffic_light_night_blink dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Light model: configuration copy and controller state
  logic [11:0] m_thr;
  logic [7:0]  m_gsec;
  logic [7:0]  m_ysec;
  logic [7:0]  m_rsec;
  logic [1:0]  m_phase;
  logic [8:0]  m_ticks;
  logic        m_blink;
  logic        m_dark;
  logic [7:0]  m_count;

  logic [11:0] level_q[$];
  lamp_beat_t  lamp_q[$];
  int          n_queued;
  int          n_accepted;
  int          n_errors;
  int          n_cycles;
  int          send_idle;
  int          recv_stall;
  logic        in_took;

  task automatic report(input string msg);
    if (n_errors < 50) $display("ERROR at %0t: %s", $time, msg);
    n_errors++;
  endtask

  // Phase length in seconds, a zero register counts as one second
  function automatic logic [7:0] phase_secs(input logic [1:0] ph);
    logic [7:0] s;
    case (ph)
      PH_CODE_YELLOW: s = m_ysec;
      PH_CODE_RED:    s = m_rsec;
      default:        s = m_gsec;
    endcase
    return (s == 8'd0) ? 8'd1 : s;
  endfunction

  function automatic logic [8:0] phase_ticks(input logic [1:0] ph);
    return {phase_secs(ph), 1'b0};
  endfunction

  function automatic logic [1:0] next_phase(input logic [1:0] ph);
    case (ph)
      PH_CODE_GREEN:  return PH_CODE_YELLOW;
      PH_CODE_YELLOW: return PH_CODE_RED;
      default:        return PH_CODE_GREEN;
    endcase
  endfunction

  task automatic reset_light();
    m_thr   = DARK_THRESHOLD_RST;
    m_gsec  = GREEN_SECONDS_RST;
    m_ysec  = YELLOW_SECONDS_RST;
    m_rsec  = RED_SECONDS_RST;
    m_phase = PH_CODE_GREEN;
    m_ticks = '0;
    m_blink = 1'b0;
    m_dark  = 1'b0;
    m_count = '0;
  endtask

  task automatic apply_reg(input logic [1:0] idx, input logic [11:0] data);
    case (idx)
      REG_DARK_THRESHOLD: m_thr  = data;
      REG_GREEN_SECONDS:  m_gsec = data[7:0];
      REG_YELLOW_SECONDS: m_ysec = data[7:0];
      REG_RED_SECONDS:    m_rsec = data[7:0];
      default: ;
    endcase
  endtask

  // Advance the light by one half-second tick and queue the lamp beat it shows
  task automatic advance_tick(input logic [11:0] level);
    lamp_beat_t r;
    r = '0;
    if (m_ticks == 9'd0) m_ticks = phase_ticks(m_phase);
    if (level > m_thr) begin
      // night: blink yellow, hold phase and tick count
      m_dark   = 1'b1;
      m_blink  = !m_blink;
      r.yellow = m_blink;
      r.night  = 1'b1;
    end else begin
      // back from dark: restart at green
      if (m_dark) begin
        m_dark  = 1'b0;
        m_blink = 1'b0;
        m_phase = PH_CODE_GREEN;
        m_ticks = phase_ticks(m_phase);
      end
      if (m_ticks == phase_ticks(m_phase)) begin
        m_count = phase_secs(m_phase) - 8'd1;
        m_blink = 1'b1;
      end else begin
        m_blink = !m_blink;
      end
      r.red    = (m_phase == PH_CODE_RED) && m_blink;
      r.yellow = (m_phase == PH_CODE_YELLOW) && m_blink;
      r.green  = (m_phase == PH_CODE_GREEN) && m_blink;
      r.phase  = m_phase;
      if (m_blink) begin
        r.secs  = m_count;
        m_count = m_count - 8'd1;
      end
      m_ticks = m_ticks - 9'd1;
      if (m_ticks == 9'd0) begin
        m_phase = next_phase(m_phase);
        m_ticks = phase_ticks(m_phase);
      end
    end
    lamp_q.push_back(r);
  endtask

  // Compare one result beat against the oldest expected lamp beat
  task automatic check_beat();
    lamp_beat_t e;
    if (lamp_q.size() == 0) begin
      report("result beat with nothing expected");
      return;
    end
    e = lamp_q.pop_front();
    if (out_if.red_on !== e.red)
      report($sformatf("red_on exp %0d got %0b", e.red, out_if.red_on));
    if (out_if.yellow_on !== e.yellow)
      report($sformatf("yellow_on exp %0d got %0b", e.yellow, out_if.yellow_on));
    if (out_if.green_on !== e.green)
      report($sformatf("green_on exp %0d got %0b", e.green, out_if.green_on));
    if (out_if.night_mode !== e.night)
      report($sformatf("night_mode exp %0d got %0b", e.night, out_if.night_mode));
    if (out_if.phase_now !== e.phase)
      report($sformatf("phase_now exp %0d got %0d", e.phase, out_if.phase_now));
    if (out_if.seconds_left !== e.secs)
      report($sformatf("seconds_left exp %0d got %0d", e.secs, out_if.seconds_left));
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watch both channels and the register port at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_light();
      in_took <= 1'b0;
    end else begin
      in_took <= in_if.valid && in_if.ready;
      if (out_if.valid && out_if.ready) check_beat();
      if (in_if.valid && in_if.ready) begin
        advance_tick(in_if.light_level);
        n_accepted++;
      end
      if (cfg_we) apply_reg(cfg_idx, cfg_data);
    end
  end

  // Drive the next sample beat once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (level_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_if.valid       <= 1'b1;
        in_if.light_level <= level_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_if.ready <= rst_n && ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_level(input logic [11:0] level);
    level_q.push_back(level);
    n_queued++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every sample is taken and every lamp beat has come back
  task automatic settle();
    while (n_accepted != n_queued || lamp_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_idling(input int k);
    case (k % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 46; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 46; end
      default: begin send_idle = 35; recv_stall = 35; end
    endcase
  endtask

  function automatic logic [11:0] day_level();
    if ($urandom_range(9) == 0) return m_thr;
    return 12'($urandom_range(int'(m_thr), 0));
  endfunction

  function automatic logic [11:0] night_level();
    if (m_thr == 12'hFFF) return 12'hFFF;
    if ($urandom_range(9) == 0) return m_thr + 12'd1;
    return 12'($urandom_range(4095, int'(m_thr) + 1));
  endfunction

  function automatic logic [11:0] rand_secs_data();
    int r;
    logic [7:0] s;
    r = $urandom_range(9);
    if (r == 0) s = 8'd0;
    else if (r == 1) s = 8'd255;
    else if (r < 7) s = 8'($urandom_range(4, 1));
    else s = 8'($urandom_range(255));
    return {4'($urandom_range(15)), s};
  endfunction

  function automatic logic [11:0] rand_thr();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 12'd0;
    if (r == 1) return 12'hFFF;
    return 12'($urandom_range(4095));
  endfunction

  initial begin
    int rand_ticks;
    int k;
    int n;
    int burst;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = REG_DARK_THRESHOLD;
    cfg_data          = '0;
    in_if.valid       = 1'b0;
    in_if.light_level = '0;
    out_if.ready      = 1'b0;
    n_queued          = 0;
    n_accepted        = 0;
    n_errors          = 0;
    n_cycles          = 0;
    send_idle         = 0;
    recv_stall        = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Run one full green phase at reset durations, threshold edge included
    push_level(12'd0);    push_level(12'd2000); push_level(12'd1);
    push_level(12'd1999); push_level(12'h555);  push_level(12'h2AA);
    push_level(12'd7);    push_level(12'd1000); push_level(12'h0F0);
    push_level(12'h70F);
    settle();

    // Stretch yellow just before it starts so the seconds count wraps
    write_reg(REG_YELLOW_SECONDS, 12'h003);
    set_idling(3);
    push_level(12'd0);    push_level(12'd100);  push_level(12'd200);
    push_level(12'd300);
    // Go dark, then come back to green
    push_level(12'd2001); push_level(12'hFFF);  push_level(12'hFFE);
    push_level(12'd0);    push_level(12'd5);    push_level(12'd6);
    settle();

    // Zero threshold, zero green, masked high data bits
    write_reg(REG_DARK_THRESHOLD, 12'h000);
    write_reg(REG_GREEN_SECONDS, 12'hA00);
    write_reg(REG_YELLOW_SECONDS, 12'h0FF);
    write_reg(REG_RED_SECONDS, 12'hF01);
    set_idling(1);
    push_level(12'd0); push_level(12'd1); push_level(12'd0);
    push_level(12'd0); push_level(12'd0); push_level(12'd0);
    settle();

    // Random phases: mostly day ticks with short night bursts
    rand_ticks = 0;
    k = 0;
    while (rand_ticks < RANDOM_TICKS) begin
      if (k == 1) begin
        write_reg(REG_DARK_THRESHOLD, 12'hFFF);
        write_reg(REG_GREEN_SECONDS, 12'h0FF);
        write_reg(REG_YELLOW_SECONDS, 12'h0FF);
        write_reg(REG_RED_SECONDS, 12'h0FF);
      end else if (k == 2) begin
        write_reg(REG_DARK_THRESHOLD, 12'd2048);
        write_reg(REG_GREEN_SECONDS, 12'h001);
        write_reg(REG_YELLOW_SECONDS, 12'h100);
        write_reg(REG_RED_SECONDS, 12'h001);
      end else begin
        if ($urandom_range(1)) write_reg(REG_DARK_THRESHOLD, rand_thr());
        if ($urandom_range(1)) write_reg(REG_GREEN_SECONDS, rand_secs_data());
        if ($urandom_range(1)) write_reg(REG_YELLOW_SECONDS, rand_secs_data());
        if ($urandom_range(1)) write_reg(REG_RED_SECONDS, rand_secs_data());
      end
      set_idling(k);
      n = $urandom_range(120, 30);
      burst = 0;
      repeat (n) begin
        if (burst == 0 && $urandom_range(99) < 5) burst = $urandom_range(8, 1);
        if (burst != 0) begin
          push_level(night_level());
          burst--;
        end else begin
          push_level(day_level());
        end
      end
      rand_ticks += n;
      settle();
      k++;
    end

    repeat (4) @(negedge clk);
    if (lamp_q.size() != 0) report("expected lamp beats never arrived");
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: traffic_light_night_blink.f
sv/tlnb_pkg.sv
sv/tlnb_if.sv
sv/traffic_light_night_blink.sv
tb/testbench.sv
